// ===== sv/pfa_pkg.sv =====
// Package with types, constants and state encoding for the page frame allocator.
package pfa_pkg;
  localparam int FRAMES_DEF = 64;
  localparam int PROCESSES_DEF = 16;
  localparam int MAX_PAGE_BYTES_DEF = 4096;

  localparam logic [1:0] CMD_GROW = 2'd0;
  localparam logic [1:0] CMD_SHRINK = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [0:0] REG_PAGE_SIZE = 1'd0;
  localparam logic [0:0] REG_FRAMES = 1'd1;

  localparam logic [18:0] BYTES_SAT = 19'h7FFFF;

  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] process_slot;
    logic [18:0] amount;
    logic [5:0] page_number;
  } pfa_in_t;

  typedef struct packed {
    logic out_of_memory;
    logic [18:0] process_bytes;
    logic [6:0] page_total;
    logic [5:0] frame_found;
    logic frame_valid;
  } pfa_out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_GFILL, ST_GDIV, ST_GSCAN, ST_SFIRST, ST_SRD, ST_SLOOP,
    ST_QRD, ST_QWAIT, ST_SIZE, ST_DONE
  } pfa_state_t;
endpackage

// ===== sv/pfa_ptab.sv =====
// Page-to-frame table memory, one port for writes and one registered read port.
module pfa_ptab import pfa_pkg::*; #(
  parameter int DEPTH = FRAMES_DEF * PROCESSES_DEF,
  parameter int FW = 6
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [FW-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [FW-1:0] rdata
);
  logic [FW-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/paged_frame_allocator_resize.sv =====
// Top level of the paged frame allocator: config port, sequencer and state.
//  channel | direction | handshake       | payload
//  in_     | input     | in_valid/stall  | pfa_in_t
//  out_    | output    | out_valid/stall | pfa_out_t
//  cfg_    | input     | APB write/read  | page_size, frames_in_use
// A query runs through the load, table read, wait, size and done states. A grow fills the last
// page, divides by the page size (a load, then one shared subtractor step per quotient bit),
// then scans one frame per cycle. A shrink frees a page per pass through its read and loop states.
// Reset clears the bitmap, page counts and fills at once; the table needs none.
// A waiting result holds in the output register; no new item is taken until it leaves.
module paged_frame_allocator_resize import pfa_pkg::*; #(
  parameter int FRAMES = FRAMES_DEF,
  parameter int PROCESSES = PROCESSES_DEF,
  parameter int MAX_PAGE_BYTES = MAX_PAGE_BYTES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  pfa_in_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output pfa_out_t out_data,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [2:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  localparam int FB = $clog2(FRAMES);
  localparam int CB = $clog2(FRAMES + 1);
  localparam int SB = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam int AB = $clog2(FRAMES * PROCESSES);
  localparam int DB = 20;

  logic [12:0] page_size_r;
  logic [6:0] frames_r;
  logic [FRAMES-1:0] busy_r;
  logic [CB-1:0] held_r [PROCESSES];
  logic [12:0] fill_r [PROCESSES];

  pfa_state_t state_r, state_nxt;
  pfa_in_t req_r;
  logic [SB-1:0] slot_r;
  logic [12:0] ps_r;
  logic [CB-1:0] nf_r;
  logic [19:0] rem_r;
  logic [DB-1:0] quo_r;
  logic [19:0] prem_r;
  logic [4:0] cnt_r;
  logic [CB-1:0] idx_r;
  logic [CB-1:0] pages_r;
  logic [12:0] fillw_r;
  logic oom_r;
  logic [25:0] acc_r;
  pfa_out_t out_r;
  logic out_valid_r;

  logic wr_cfg;
  assign cfg_pready = 1'b1;
  assign wr_cfg = cfg_psel && cfg_penable && cfg_pwrite;
  always_comb begin
    unique case (cfg_paddr[2])
      REG_PAGE_SIZE: cfg_prdata = {19'd0, page_size_r};
      default: cfg_prdata = {25'd0, frames_r};
    endcase
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_size_r <= 13'd32;
      frames_r <= 7'd64;
    end else if (wr_cfg && cfg_paddr[1:0] == 2'd0) begin
      if (cfg_paddr[2] == REG_PAGE_SIZE) page_size_r <= cfg_pwdata[12:0];
      else frames_r <= cfg_pwdata[6:0];
    end
  end

  logic [12:0] eff_ps;
  logic [CB-1:0] eff_nf;
  always_comb begin
    if (page_size_r == 13'd0) eff_ps = 13'd1;
    else if (32'(page_size_r) > MAX_PAGE_BYTES) eff_ps = 13'(MAX_PAGE_BYTES);
    else eff_ps = page_size_r;
    if (32'(frames_r) > FRAMES) eff_nf = CB'(FRAMES);
    else eff_nf = CB'(frames_r);
  end

  logic accept;
  assign in_stall = (state_r != ST_IDLE) || out_valid_r;
  assign accept = in_valid && !in_stall;

  logic [CB-1:0] held_s;
  logic [12:0] fill_s;
  assign held_s = held_r[slot_r];
  assign fill_s = fill_r[slot_r];

  logic tab_we;
  logic [AB-1:0] tab_wa, tab_ra;
  logic [FB-1:0] tab_rd;
  logic [FB-1:0] qpage;
  assign qpage = FB'(req_r.page_number);
  pfa_ptab #(.DEPTH(FRAMES * PROCESSES), .FW(FB)) u_tab (
    .clk(clk), .we(tab_we), .waddr(tab_wa), .wdata(idx_r[FB-1:0]),
    .raddr(tab_ra), .rdata(tab_rd)
  );

  logic [12:0] room;
  assign room = (fill_s < ps_r) ? ps_r - fill_s : 13'd0;
  logic [20:0] trial;
  assign trial = {prem_r, quo_r[DB-1]} - {8'd0, ps_r};
  logic grant;
  assign grant = (state_r == ST_GSCAN) && idx_r < nf_r && quo_r != '0 &&
                 !busy_r[idx_r[FB-1:0]] && held_s < CB'(FRAMES);
  logic [CB-1:0] lastpg;
  assign lastpg = held_s - CB'(1);

  always_comb begin
    tab_we = grant;
    tab_wa = AB'({slot_r, held_s[FB-1:0]});
    tab_ra = AB'({slot_r, lastpg[FB-1:0]});
    if (state_r == ST_QRD) tab_ra = AB'({slot_r, qpage});
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_LOAD;
      ST_LOAD: begin
        if (32'(req_r.process_slot) >= PROCESSES) state_nxt = ST_DONE;
        else if (req_r.cmd == CMD_GROW) state_nxt = ST_GFILL;
        else if (req_r.cmd == CMD_SHRINK) state_nxt = ST_SFIRST;
        else if (req_r.cmd == CMD_QUERY) state_nxt = ST_QRD;
        else state_nxt = ST_SIZE;
      end
      ST_GFILL: state_nxt = ST_GDIV;
      ST_GDIV: if (cnt_r == 5'd0) state_nxt = ST_GSCAN;
      ST_GSCAN: if (!(idx_r < nf_r && quo_r != '0 && held_s < CB'(FRAMES)))
        state_nxt = ST_SIZE;
      ST_SFIRST: begin
        if (held_s == '0 || req_r.amount < 19'(fill_s)) state_nxt = ST_SIZE;
        else state_nxt = ST_SRD;
      end
      ST_SRD: state_nxt = ST_SLOOP;
      ST_SLOOP: state_nxt = (rem_r >= 20'(ps_r) && lastpg != '0) ? ST_SRD : ST_SIZE;
      ST_QRD: state_nxt = ST_QWAIT;
      ST_QWAIT: state_nxt = ST_SIZE;
      ST_SIZE: state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
      for (int i = 0; i < PROCESSES; i++) begin
        held_r[i] <= '0;
        fill_r[i] <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: if (accept) req_r <= in_data;
        ST_LOAD: begin
          slot_r <= SB'(req_r.process_slot);
          ps_r <= eff_ps;
          nf_r <= eff_nf;
          idx_r <= '0;
          oom_r <= 1'b0;
          fillw_r <= '0;
          out_r <= '0;
        end
        ST_GFILL: begin
          if (held_s != '0) begin
            if (req_r.amount <= 19'(room)) begin
              fill_r[slot_r] <= fill_s + 13'(req_r.amount);
              rem_r <= '0;
            end else begin
              if (fill_s < ps_r) fill_r[slot_r] <= ps_r;
              rem_r <= {1'b0, req_r.amount} - 20'(room);
            end
          end else rem_r <= {1'b0, req_r.amount};
          quo_r <= '0;
          cnt_r <= 5'(DB - 1);
          prem_r <= '0;
        end
        ST_GDIV: begin
          // First pass loads rem+ps-1, then restoring division by the page size.
          if (cnt_r == 5'(DB - 1) && prem_r == '0 && fillw_r == '0) begin
            quo_r <= rem_r + 20'(ps_r) - 20'd1;
            fillw_r <= 13'd1;
          end else begin
            if (!trial[20]) prem_r <= trial[19:0];
            else prem_r <= {prem_r[18:0], quo_r[DB-1]};
            quo_r <= {quo_r[DB-2:0], !trial[20]};
            cnt_r <= cnt_r - 5'd1;
          end
        end
        ST_GSCAN: begin
          if (grant) begin
            busy_r[idx_r[FB-1:0]] <= 1'b1;
            held_r[slot_r] <= held_s + CB'(1);
            fill_r[slot_r] <= (quo_r == 20'd1) ? rem_r[12:0] : ps_r;
            quo_r <= quo_r - 20'd1;
            rem_r <= (rem_r > 20'(ps_r)) ? rem_r - 20'(ps_r) : 20'd0;
          end
          if (idx_r < nf_r && quo_r != '0 && held_s < CB'(FRAMES))
            idx_r <= idx_r + CB'(1);
          else oom_r <= (quo_r != '0);
        end
        ST_SFIRST: begin
          if (held_s != '0) begin
            if (req_r.amount >= 19'(fill_s)) rem_r <= {1'b0, req_r.amount} - 20'(fill_s);
            else fill_r[slot_r] <= fill_s - 13'(req_r.amount);
          end
        end
        ST_SRD: ;
        ST_SLOOP: begin
          busy_r[tab_rd] <= 1'b0;
          held_r[slot_r] <= lastpg;
          if (rem_r >= 20'(ps_r)) rem_r <= rem_r - 20'(ps_r);
          else rem_r <= '0;
          if (lastpg == '0) fill_r[slot_r] <= '0;
          else if (rem_r == '0 || rem_r >= 20'(ps_r)) fill_r[slot_r] <= ps_r;
          else fill_r[slot_r] <= ps_r - 13'(rem_r);
        end
        ST_QRD: ;
        ST_QWAIT: begin
          if (req_r.cmd == CMD_QUERY && 32'(req_r.page_number) < 32'(held_s)) begin
            out_r.frame_found <= 6'(tab_rd);
            out_r.frame_valid <= 1'b1;
          end
        end
        ST_SIZE: acc_r <= (held_s == '0) ? 26'd0 :
          26'(lastpg) * 26'(ps_r) + 26'(fill_s);
        ST_DONE: begin
          if (32'(req_r.process_slot) < PROCESSES) begin
            out_r.out_of_memory <= oom_r;
            out_r.process_bytes <= (acc_r > 26'(BYTES_SAT)) ? BYTES_SAT : acc_r[18:0];
            out_r.page_total <= 7'(held_s);
          end
          out_valid_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;
endmodule
